FILE: design/fir_line_filter_mirrored_border_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line FIR filter
// Implication checks, same cycle and next cycle, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FIR_LINE_FILTER_MIRRORED_BORDER_MACROS_SVH
`define FIR_LINE_FILTER_MIRRORED_BORDER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FLF_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("flf: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define FLF_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("flf: next-cycle check failed");

`endif

FILE: design/flf_pkg.sv
// ----------------------------------------------------------------------------
// flf_pkg
// Shared constants, register codes and job types of the line FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package flf_pkg;

    localparam int IN_BITS        = 16;
    localparam int OUT_BITS       = 22;
    localparam int COEF_FIELD     = 16;
    localparam int FRAC_BITS      = 14;
    localparam int HW_BITS        = 3;
    localparam int HW_LIMIT       = 7;
    localparam int NUM_COEF_WORDS = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_ADDR_BITS  = 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = 2;
    localparam int QCNT_BITS      = 3;
    localparam int LANE_GROUP     = 4;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_HALF_WIDTH = 3'd0;
    localparam reg_idx_t REG_COEF0      = 3'd1;
    localparam reg_idx_t REG_COEF1      = 3'd2;
    localparam reg_idx_t REG_COEF2      = 3'd3;
    localparam reg_idx_t REG_COEF3      = 3'd4;

    localparam logic [CFG_DATA_BITS-1:0] COEF0_RESET = 64'd16384;

    typedef logic [1:0] job_kind_t;

    localparam job_kind_t JOB_NORMAL = 2'd0;
    localparam job_kind_t JOB_DRAIN  = 2'd1;
    localparam job_kind_t JOB_SHORT  = 2'd2;

    typedef struct packed {
        job_kind_t            kind;
        logic [HW_BITS-1:0]   h;
    } job_ctrl_t;

    typedef struct packed {
        logic [HW_BITS-1:0]                                half_width;
        logic [NUM_COEF_WORDS-1:0][CFG_DATA_BITS-1:0]      coef_words;
    } cfg_regs_t;

endpackage

`default_nettype wire

FILE: design/flf_sample_if.sv
// ----------------------------------------------------------------------------
// flf_sample_if
// Input channel: one pixel word per handshake, with end-of-line mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface flf_sample_if;
    import flf_pkg::*;

    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] sample;
    logic               last_in_line;

    modport source (output valid, output sample, output last_in_line, input ready);
    modport sink   (input valid, input sample, input last_in_line, output ready);
endinterface

`default_nettype wire

FILE: design/flf_result_if.sv
// ----------------------------------------------------------------------------
// flf_result_if
// Output channel: one filtered word per handshake, with line flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface flf_result_if;
    import flf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] value;
    logic                       last_of_line;
    logic                       short_line;

    modport source (output valid, output value, output last_of_line, output short_line,
                    input ready);
    modport sink   (input valid, input value, input last_of_line, input short_line,
                    output ready);
endinterface

`default_nettype wire

FILE: design/flf_cfg_regs.sv
// ----------------------------------------------------------------------------
// flf_cfg_regs
// APB register file: half width and four packed coefficient words.
// ----------------------------------------------------------------------------
`default_nettype none

module flf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [flf_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [flf_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [flf_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output flf_pkg::cfg_regs_t                 cfg
);
    import flf_pkg::*;

    logic [HW_BITS-1:0]                           half_width_reg;
    logic [NUM_COEF_WORDS-1:0][CFG_DATA_BITS-1:0] coef_reg;
    reg_idx_t                                     idx;
    logic                                         wr;

    assign idx    = paddr[CFG_ADDR_BITS-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= '0;
            coef_reg[0]    <= COEF0_RESET;
            coef_reg[1]    <= '0;
            coef_reg[2]    <= '0;
            coef_reg[3]    <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_HALF_WIDTH: half_width_reg <= pwdata[HW_BITS-1:0];
                REG_COEF0:      coef_reg[0]    <= pwdata;
                REG_COEF1:      coef_reg[1]    <= pwdata;
                REG_COEF2:      coef_reg[2]    <= pwdata;
                REG_COEF3:      coef_reg[3]    <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HALF_WIDTH: prdata = CFG_DATA_BITS'(half_width_reg);
            REG_COEF0:      prdata = coef_reg[0];
            REG_COEF1:      prdata = coef_reg[1];
            REG_COEF2:      prdata = coef_reg[2];
            REG_COEF3:      prdata = coef_reg[3];
            default:        prdata = '0;
        endcase
    end

    assign cfg.half_width = half_width_reg;
    assign cfg.coef_words = coef_reg;

endmodule

`default_nettype wire

FILE: design/flf_front.sv
// ----------------------------------------------------------------------------
// flf_front
// Takes samples, shifts the window, tracks line position and issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module flf_front #(
    parameter  int MAX_HALF_WIDTH = 7,
    parameter  int SAMPLE_BITS    = 16,
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1,
    localparam int CNT_W          = $clog2(WIN_DEPTH + 1),
    localparam int SB             = (SAMPLE_BITS < flf_pkg::IN_BITS) ? SAMPLE_BITS
                                                                     : flf_pkg::IN_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  flf_pkg::cfg_regs_t              cfg,
    flf_sample_if.sink                      samples,
    input  logic                            q_full,
    output logic                            push,
    output flf_pkg::job_ctrl_t              push_ctrl,
    output logic [CNT_W-1:0]                push_n,
    output logic [WIN_DEPTH-1:0][SB-1:0]    push_win
);
    import flf_pkg::*;

    localparam int HMAX = (MAX_HALF_WIDTH < HW_LIMIT) ? MAX_HALF_WIDTH : HW_LIMIT;
    localparam logic [HW_BITS-1:0] H_CAP = HW_BITS'(HMAX);
    localparam int CMP_W = (CNT_W > HW_BITS) ? CNT_W : HW_BITS;

    logic [WIN_DEPTH-1:0][SB-1:0] win_reg;
    logic [WIN_DEPTH-1:0][SB-1:0] win_next;
    logic [CNT_W-1:0]             pos_reg;
    logic [CNT_W-1:0]             pos_next;
    logic [HW_BITS-1:0]           h;
    logic                         accept;
    logic                         pos_ge_h;

    assign samples.ready = !q_full;
    assign accept        = samples.valid && samples.ready;

    assign h        = (cfg.half_width > H_CAP) ? H_CAP : cfg.half_width;
    assign pos_ge_h = CMP_W'(pos_reg) >= CMP_W'(h);
    assign win_next = {win_reg[WIN_DEPTH-2:0], samples.sample[SB-1:0]};

    always_comb
    begin
        if (samples.last_in_line)
            pos_next = '0;
        else if (pos_reg == CNT_W'(WIN_DEPTH))
            pos_next = pos_reg;
        else
            pos_next = pos_reg + 1'b1;
    end

    always_comb
    begin
        push_ctrl.h = h;
        if (!samples.last_in_line)
            push_ctrl.kind = JOB_NORMAL;
        else if (pos_ge_h)
            push_ctrl.kind = JOB_DRAIN;
        else
            push_ctrl.kind = JOB_SHORT;
    end

    assign push     = accept && (samples.last_in_line || pos_ge_h);
    assign push_n   = pos_reg;
    assign push_win = win_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            win_reg <= win_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/flf_job_queue.sv
// ----------------------------------------------------------------------------
// flf_job_queue
// Short FIFO of filter jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fir_line_filter_mirrored_border_macros.svh"

module flf_job_queue #(
    parameter  int MAX_HALF_WIDTH = 7,
    parameter  int SAMPLE_BITS    = 16,
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1,
    localparam int CNT_W          = $clog2(WIN_DEPTH + 1),
    localparam int SB             = (SAMPLE_BITS < flf_pkg::IN_BITS) ? SAMPLE_BITS
                                                                     : flf_pkg::IN_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  flf_pkg::job_ctrl_t              push_ctrl,
    input  logic [CNT_W-1:0]                push_n,
    input  logic [WIN_DEPTH-1:0][SB-1:0]    push_win,
    input  logic                            pop,
    output flf_pkg::job_ctrl_t              head_ctrl,
    output logic [CNT_W-1:0]                head_n,
    output logic [WIN_DEPTH-1:0][SB-1:0]    head_win,
    output logic                            full,
    output logic                            empty
);
    import flf_pkg::*;

    job_ctrl_t                    ctrl_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]             n_mem    [QUEUE_DEPTH];
    logic [WIN_DEPTH-1:0][SB-1:0] win_mem  [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]         wr_ptr_reg;
    logic [QPTR_BITS-1:0]         rd_ptr_reg;
    logic [QCNT_BITS-1:0]         cnt_reg;

    assign full  = cnt_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_mem[wr_ptr_reg] <= push_ctrl;
            n_mem[wr_ptr_reg]    <= push_n;
            win_mem[wr_ptr_reg]  <= push_win;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign head_ctrl = ctrl_mem[rd_ptr_reg];
    assign head_n    = n_mem[rd_ptr_reg];
    assign head_win  = win_mem[rd_ptr_reg];

    `FLF_ASSERT_IMP(a_push_has_room, clk, rst_n, push, !full)
    `FLF_ASSERT_IMP(a_pop_has_job, clk, rst_n, pop, !empty)
    `FLF_ASSERT_NXT(a_cnt_tracks_ptrs, clk, rst_n, push && !pop && !full,
                    cnt_reg != '0 && $past(wr_ptr_reg) != wr_ptr_reg)

endmodule

`default_nettype wire

FILE: design/flf_back.sv
// ----------------------------------------------------------------------------
// flf_back
// Job sequencer and filter pipeline: tap select, multiply, group add, output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fir_line_filter_mirrored_border_macros.svh"

module flf_back #(
    parameter  int MAX_HALF_WIDTH = 7,
    parameter  int SAMPLE_BITS    = 16,
    parameter  int COEF_BITS      = 16,
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1,
    localparam int CNT_W          = $clog2(WIN_DEPTH + 1),
    localparam int SB             = (SAMPLE_BITS < flf_pkg::IN_BITS) ? SAMPLE_BITS
                                                                     : flf_pkg::IN_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  flf_pkg::cfg_regs_t              cfg,
    input  flf_pkg::job_ctrl_t              head_ctrl,
    input  logic [CNT_W-1:0]                head_n,
    input  logic [WIN_DEPTH-1:0][SB-1:0]    head_win,
    input  logic                            empty,
    output logic                            pop,
    flf_result_if.source                    results
);
    import flf_pkg::*;

    localparam int HMAX   = (MAX_HALF_WIDTH < HW_LIMIT) ? MAX_HALF_WIDTH : HW_LIMIT;
    localparam int TAPS   = 2 * HMAX + 1;
    localparam int CB     = (COEF_BITS < COEF_FIELD) ? COEF_BITS : COEF_FIELD;
    localparam int KW     = $clog2(WIN_DEPTH);
    localparam int IDX_W  = CNT_W + 2;
    localparam int PW     = SB + CB + 1;
    localparam int TW     = PW - FRAC_BITS;
    localparam int NGRP   = (TAPS + LANE_GROUP - 1) / LANE_GROUP;
    localparam int GW     = TW + $clog2(LANE_GROUP);
    localparam int SUM_W  = GW + 2;
    localparam int ACC_W  = ((SUM_W > OUT_BITS) ? SUM_W : OUT_BITS) + 1;
    localparam int HALF_LSB = 1 << (FRAC_BITS - 1);
    localparam logic signed [IDX_W-1:0] WIN_S = IDX_W'(WIN_DEPTH);
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        $signed({{(ACC_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] OUT_MIN =
        $signed({{(ACC_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}});

    // sequencer
    logic               adv;
    logic               issue;
    logic               busy_reg;
    logic               busy_next;
    logic [HW_BITS-1:0] d_reg;
    logic [HW_BITS-1:0] d_next;
    logic [HW_BITS-1:0] d_cur;
    logic               is_drain;
    logic               is_short;

    // select stage
    logic signed [IDX_W-1:0] n_s;
    logic signed [IDX_W-1:0] d_s;
    logic signed [IDX_W-1:0] h_s;
    logic signed [IDX_W-1:0] i_s [TAPS];
    logic signed [IDX_W-1:0] p_s [TAPS];
    logic signed [IDX_W-1:0] k_s [TAPS];
    logic [SB-1:0]           smp_sel [TAPS];
    logic                    a_valid_reg;
    logic                    a_last_reg;
    logic                    a_short_reg;
    logic [SB-1:0]           a_smp_reg [TAPS];

    // multiply stage
    logic signed [CB-1:0]    tap_s [TAPS];
    logic signed [PW-1:0]    prod [TAPS];
    logic signed [PW-1:0]    rnd [TAPS];
    logic                    b_valid_reg;
    logic                    b_last_reg;
    logic                    b_short_reg;
    logic signed [TW-1:0]    b_term_reg [TAPS];

    // group add stage
    logic signed [GW-1:0]    c_sum [NGRP];
    logic                    c_valid_reg;
    logic                    c_last_reg;
    logic                    c_short_reg;
    logic signed [GW-1:0]    c_grp_reg [NGRP];

    // output
    logic signed [ACC_W-1:0]    total;
    logic signed [OUT_BITS-1:0] sat_value;
    logic                       out_valid_reg;
    logic                       out_last_reg;
    logic                       out_short_reg;
    logic signed [OUT_BITS-1:0] out_value_reg;

    assign adv      = !out_valid_reg || results.ready;
    assign issue    = adv && !empty;
    assign d_cur    = busy_reg ? d_reg : head_ctrl.h;
    assign is_drain = head_ctrl.kind == JOB_DRAIN;
    assign is_short = head_ctrl.kind == JOB_SHORT;
    assign pop      = issue && (!is_drain || d_cur == '0);

    always_comb
    begin
        busy_next = busy_reg;
        d_next    = d_reg;
        if (issue && is_drain && d_cur != '0)
        begin
            busy_next = 1'b1;
            d_next    = d_cur - 1'b1;
        end
        else if (pop)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            d_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            d_reg    <= d_next;
        end
    end

    // window position of each tap, reflect-101 at both ends
    always_comb
    begin
        n_s = $signed(IDX_W'(head_n));
        d_s = $signed(IDX_W'(d_cur));
        h_s = $signed(IDX_W'(head_ctrl.h));
        for (int t = 0; t < TAPS; t++)
        begin
            i_s[t] = $signed(IDX_W'(t)) - h_s;
            p_s[t] = n_s - d_s + i_s[t];
            if (p_s[t] < 0)
                k_s[t] = n_s + p_s[t];
            else if (is_drain && i_s[t] > d_s)
                k_s[t] = i_s[t] - d_s;
            else
                k_s[t] = d_s - i_s[t];
            if (!is_short && i_s[t] <= h_s && k_s[t] >= 0 && k_s[t] < WIN_S)
                smp_sel[t] = head_win[k_s[t][KW-1:0]];
            else
                smp_sel[t] = '0;
        end
    end

    for (genvar t = 0; t < TAPS; t++)
    begin : g_tap
        localparam int WORD = t / LANE_GROUP;
        localparam int OFS  = (t % LANE_GROUP) * COEF_FIELD;
        assign tap_s[t] = $signed(cfg.coef_words[WORD][OFS +: CB]);
    end

    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            prod[t] = PW'($signed({1'b0, a_smp_reg[t]})) * PW'(tap_s[t]);
            rnd[t]  = prod[t] + $signed(PW'(HALF_LSB));
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            c_sum[g] = '0;
            for (int j = 0; j < LANE_GROUP; j++)
            begin
                if (g * LANE_GROUP + j < TAPS)
                    c_sum[g] = c_sum[g] + GW'(b_term_reg[g * LANE_GROUP + j]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
            total = total + ACC_W'(c_grp_reg[g]);
        if (total > OUT_MAX)
            sat_value = OUT_MAX[OUT_BITS-1:0];
        else if (total < OUT_MIN)
            sat_value = OUT_MIN[OUT_BITS-1:0];
        else
            sat_value = total[OUT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= issue;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_last_reg  <= is_short || (is_drain && d_cur == '0);
            a_short_reg <= is_short;
            for (int t = 0; t < TAPS; t++)
                a_smp_reg[t] <= smp_sel[t];

            b_last_reg  <= a_last_reg;
            b_short_reg <= a_short_reg;
            for (int t = 0; t < TAPS; t++)
                b_term_reg[t] <= rnd[t][PW-1:FRAC_BITS];

            c_last_reg  <= b_last_reg;
            c_short_reg <= b_short_reg;
            for (int g = 0; g < NGRP; g++)
                c_grp_reg[g] <= c_sum[g];

            out_last_reg  <= c_last_reg;
            out_short_reg <= c_short_reg;
            out_value_reg <= sat_value;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.value        = out_value_reg;
    assign results.last_of_line = out_last_reg;
    assign results.short_line   = out_short_reg;

    `FLF_ASSERT_IMP(a_drain_holds_head, clk, rst_n, busy_reg,
                    !empty && head_ctrl.kind == JOB_DRAIN && d_reg < head_ctrl.h)
    `FLF_ASSERT_IMP(a_short_is_zero_last, clk, rst_n, out_valid_reg && out_short_reg,
                    out_value_reg == '0 && out_last_reg)
    `FLF_ASSERT_NXT(a_stall_freezes_pipe, clk, rst_n, out_valid_reg && !results.ready,
                    out_valid_reg && $stable(c_valid_reg) && $stable(busy_reg))

endmodule

`default_nettype wire

FILE: design/fir_line_filter_mirrored_border.sv
// ----------------------------------------------------------------------------
// fir_line_filter_mirrored_border
// Odd-length FIR (up to 15 taps) along image lines, reflect-101 borders.
// samples: one pixel word per handshake, last_in_line closes the line.
// results: filtered words; last_of_line marks a line's final word,
//   short_line flags a line shorter than half_width+1 (one zero word).
// APB: half_width at 0x00, coefficient words at 0x08..0x20, 64-bit data.
// Throughput: one sample per cycle while the queue is not full. An accepted
//   sample completes a word via queue, tap select, multiply, add, output.
// A line end emits half_width+1 words, consecutive unless results stalls; the
//   four-entry job queue absorbs samples meanwhile, then samples.ready drops.
// Reset clears the window, line position and registers (half_width 0,
//   tap 0 = 1.0); no clearing pass, samples are taken right away.
// When results stalls, the output word holds, the pipeline freezes and
//   the queue fills before input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_line_filter_mirrored_border #(
    parameter int MAX_HALF_WIDTH = 7,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [flf_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [flf_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [flf_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    flf_sample_if.sink                         samples,
    flf_result_if.source                       results
);
    import flf_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int SB        = (SAMPLE_BITS < IN_BITS) ? SAMPLE_BITS : IN_BITS;

    cfg_regs_t                    cfg;
    logic                         push;
    job_ctrl_t                    push_ctrl;
    logic [CNT_W-1:0]             push_n;
    logic [WIN_DEPTH-1:0][SB-1:0] push_win;
    logic                         pop;
    job_ctrl_t                    head_ctrl;
    logic [CNT_W-1:0]             head_n;
    logic [WIN_DEPTH-1:0][SB-1:0] head_win;
    logic                         q_full;
    logic                         q_empty;

    flf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flf_front #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .samples   (samples),
        .q_full    (q_full),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_n    (push_n),
        .push_win  (push_win)
    );

    flf_job_queue #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_n    (push_n),
        .push_win  (push_win),
        .pop       (pop),
        .head_ctrl (head_ctrl),
        .head_n    (head_n),
        .head_win  (head_win),
        .full      (q_full),
        .empty     (q_empty)
    );

    flf_back #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head_ctrl (head_ctrl),
        .head_n    (head_n),
        .head_win  (head_win),
        .empty     (q_empty),
        .pop       (pop),
        .results   (results)
    );

endmodule

`default_nettype wire
